// ===== hdl/bdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdc_pkg: shared types and constants of the bounded distribution counter
// Row geometry, count modulus, and the command and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bdc_pkg;

  localparam int unsigned MaxTotal = 1024;
  localparam int unsigned RowDepth = MaxTotal + 1;
  localparam int unsigned IdxW     = $clog2(RowDepth);
  localparam int unsigned AmtW     = 11;
  localparam int unsigned CntW     = 30;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [AmtW-1:0] amt_t;
  typedef logic [CntW-1:0] cnt_t;

  localparam cnt_t WayMod      = 30'd1000000007;
  localparam amt_t MaxTotalAmt = amt_t'(MaxTotal);
  localparam idx_t LastIdx     = idx_t'(MaxTotal);

  // controller -> datapath
  typedef struct packed {
    logic start;   // latch a new word and its limits
    logic issue;   // read the next row entry
    logic clear;   // write one entry of the restore sweep
    logic push;    // move the held result into the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic at_top;      // the entry being read is the last of the row
    logic pipe_empty;  // no entry in flight
    logic clear_done;  // the restore sweep is on its last entry
    logic run_last;    // the current word closes its run
    logic out_free;    // the output register can take a result
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/bdc_if.sv =====
// ----------------------------------------------------------------------------
// bdc_if: channel interfaces of the bounded distribution counter
// Valid/ready channels for the configuration, recipient and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdc_cfg_if;
  logic          valid;
  logic          ready;
  bdc_pkg::amt_t total_amount;

  modport source (output valid, output total_amount, input ready);
  modport sink   (input valid, input total_amount, output ready);
endinterface

interface bdc_in_if;
  logic          valid;
  logic          ready;
  bdc_pkg::amt_t recipient_limit;
  logic          last_recipient;

  modport source (output valid, output recipient_limit, output last_recipient, input ready);
  modport sink   (input valid, input recipient_limit, input last_recipient, output ready);
endinterface

interface bdc_out_if;
  logic          valid;
  logic          ready;
  bdc_pkg::cnt_t way_count;

  modport source (output valid, output way_count, input ready);
  modport sink   (input valid, input way_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/bounded_distribution_counter_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_distribution_counter_unit: bounded composition counter, mod 1e9+7
// Counts the ways to share a configured total among a run of recipients,
// each taking at most its own limit.
// ----------------------------------------------------------------------------
//
//   channel   dir  words                          handshake
//   cfg_i     in   total_amount                   valid/ready, ready always high
//   item_i    in   recipient_limit, last_recipient valid/ready
//   result_o  out  way_count                      valid/ready, one word per run
//
// A word makes one pass over entries 0 to T of the count row, T =
// min(total_amount, 1024), one entry per cycle through a three-stage
// read/accumulate/write pipeline, plus drain. A word that closes a run adds a
// restore sweep of the count RAM and a load of the result register.
// After reset the same restore sweep runs before the first word is taken.
// The result register holds its word until taken; the next word is accepted
// meanwhile and stalls only if its own result finds the register still full.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_distribution_counter_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bdc_cfg_if.sink   cfg_i,
  bdc_in_if.sink    item_i,
  bdc_out_if.source result_o
);

  bdc_pkg::ctrl_cmd_t  cmd;
  bdc_pkg::dp_status_t status;
  logic                item_ready;

  assign cfg_i.ready  = 1'b1;
  assign item_i.ready = item_ready;

  bdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bdc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_total_i (cfg_i.total_amount),
    .limit_i     (item_i.recipient_limit),
    .last_i      (item_i.last_recipient),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .way_count_o (result_o.way_count)
  );

endmodule

`default_nettype wire

// ===== hdl/bdc_ram.sv =====
// ----------------------------------------------------------------------------
// bdc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_ram #(
  parameter int unsigned Width = 30,
  parameter int unsigned Depth = 1025
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/bdc_datapath.sv =====
// ----------------------------------------------------------------------------
// bdc_datapath: count row, prefix row and the modular update pipeline
// Three-stage pass over the row: read count, accumulate the running prefix,
// subtract the prefix that leaves the window and write the new count back.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire bdc_pkg::amt_t      cfg_total_i,
  input  wire bdc_pkg::amt_t      limit_i,
  input  wire logic               last_i,
  input  wire bdc_pkg::ctrl_cmd_t cmd_i,
  output bdc_pkg::dp_status_t     status_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output bdc_pkg::cnt_t           way_count_o
);

  bdc_pkg::amt_t total_q;
  bdc_pkg::amt_t top_now, lim_now;
  bdc_pkg::idx_t top_q, lim_q;
  logic          last_q;

  bdc_pkg::idx_t iss_idx_q, iss_idx_d;
  logic          s1_vld_q, s2_vld_q;
  bdc_pkg::idx_t s1_idx_q, s2_idx_q;
  bdc_pkg::cnt_t run_q, run_base, run_new;
  logic [bdc_pkg::CntW:0] sum;
  bdc_pkg::cnt_t s2_run_q;
  logic          s2_sub_q;
  bdc_pkg::cnt_t new_cnt;

  bdc_pkg::idx_t clr_idx_q;
  bdc_pkg::cnt_t res_q, way_q;
  logic          out_vld_q;

  bdc_pkg::cnt_t cnt_rdata, pref_rdata;
  logic          cnt_we;
  bdc_pkg::idx_t cnt_waddr, pref_raddr;
  bdc_pkg::cnt_t cnt_wdata;

  // effective total and clipped limit
  assign top_now = (total_q > bdc_pkg::MaxTotalAmt) ? bdc_pkg::MaxTotalAmt : total_q;
  assign lim_now = (limit_i > top_now) ? top_now : limit_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      last_q    <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      clr_idx_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        total_q <= cfg_total_i;
      end
      if (cmd_i.start) begin
        last_q <= last_i;
      end
      s1_vld_q <= cmd_i.issue;
      s2_vld_q <= s1_vld_q;
      if (cmd_i.clear) begin
        clr_idx_q <= (clr_idx_q == bdc_pkg::LastIdx) ? '0 : clr_idx_q + bdc_pkg::idx_t'(1);
      end
      if (cmd_i.push) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign iss_idx_d = cmd_i.start ? '0 :
                     cmd_i.issue ? iss_idx_q + bdc_pkg::idx_t'(1) : iss_idx_q;

  // stage 1: running prefix sum
  assign run_base = (s1_idx_q == '0) ? '0 : run_q;
  assign sum      = {1'b0, run_base} + {1'b0, cnt_rdata};
  assign run_new  = (sum >= {1'b0, bdc_pkg::WayMod}) ?
                    bdc_pkg::cnt_t'(sum - {1'b0, bdc_pkg::WayMod}) : sum[bdc_pkg::CntW-1:0];
  assign pref_raddr = s1_idx_q - lim_q - bdc_pkg::idx_t'(1);

  // stage 2: drop the prefix that slid out of the window; wraps to the right
  // residue because the result is below the modulus
  assign new_cnt = !s2_sub_q ? s2_run_q :
                   (s2_run_q >= pref_rdata) ? s2_run_q - pref_rdata :
                   s2_run_q - pref_rdata + bdc_pkg::WayMod;

  always_ff @(posedge clk_i) begin
    iss_idx_q <= iss_idx_d;
    if (cmd_i.start) begin
      top_q <= bdc_pkg::idx_t'(top_now);
      lim_q <= bdc_pkg::idx_t'(lim_now);
    end
    s1_idx_q <= iss_idx_q;
    if (s1_vld_q) begin
      run_q <= run_new;
    end
    s2_idx_q <= s1_idx_q;
    s2_run_q <= run_new;
    s2_sub_q <= s1_idx_q > lim_q;
    if (s2_vld_q && (s2_idx_q == top_q)) begin
      res_q <= new_cnt;
    end
    if (cmd_i.push) begin
      way_q <= res_q;
    end
  end

  // restore sweep owns the write port while it runs
  always_comb begin
    if (cmd_i.clear) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_idx_q;
      cnt_wdata = (clr_idx_q == '0) ? bdc_pkg::cnt_t'(1) : '0;
    end else begin
      cnt_we    = s2_vld_q;
      cnt_waddr = s2_idx_q;
      cnt_wdata = new_cnt;
    end
  end

  bdc_ram #(
    .Width (bdc_pkg::CntW),
    .Depth (bdc_pkg::RowDepth)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (iss_idx_q),
    .rdata_o (cnt_rdata)
  );

  bdc_ram #(
    .Width (bdc_pkg::CntW),
    .Depth (bdc_pkg::RowDepth)
  ) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (s1_vld_q),
    .waddr_i (s1_idx_q),
    .wdata_i (run_new),
    .raddr_i (pref_raddr),
    .rdata_o (pref_rdata)
  );

  assign status_o.at_top     = (iss_idx_q == top_q);
  assign status_o.pipe_empty = !s1_vld_q && !s2_vld_q;
  assign status_o.clear_done = (clr_idx_q == bdc_pkg::LastIdx);
  assign status_o.run_last   = last_q;
  assign status_o.out_free   = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign way_count_o = way_q;

endmodule

`default_nettype wire

// ===== hdl/bdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdc_ctrl: sequencing controller of the bounded distribution counter
// Steps each word through the row pass and the drain, and a word that closes
// a run also through the restore sweep and the hand-off of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire bdc_pkg::dp_status_t status_i,
  output bdc_pkg::ctrl_cmd_t       cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRun   = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StClear = 3'd3;
  localparam logic [2:0] StPush  = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StRun;
        end
      end
      StRun: begin
        cmd_o.issue = 1'b1;
        if (status_i.at_top) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (status_i.pipe_empty) begin
          state_d = status_i.run_last ? StClear : StIdle;
        end
      end
      StClear: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_done) begin
          state_d = status_i.run_last ? StPush : StIdle;
        end
      end
      StPush: begin
        // hold until the output register frees up
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== dv/bounded_distribution_counter_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_distribution_counter_unit_tb: self-checking bench of the counter
// Drives recipient words in runs under a range of totals, including totals
// changed while a run is open. An in-bench row model predicts each way
// count, and every result word is checked against the oldest prediction.
// ----------------------------------------------------------------------------

class way_count_board;
  bdc_pkg::cnt_t  count_row[bdc_pkg::MaxTotal+1];
  bdc_pkg::cnt_t  prefix_row[bdc_pkg::MaxTotal+1];
  bdc_pkg::amt_t  total;
  bdc_pkg::cnt_t  expected_q[$];
  int             errors;

  function new();
    total  = '0;
    errors = 0;
    clear_row();
  endfunction

  function void clear_row();
    foreach (count_row[j]) count_row[j] = '0;
    count_row[0] = bdc_pkg::cnt_t'(1);
  endfunction

  function void set_total(bdc_pkg::amt_t value);
    total = value;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Replace the row by its windowed prefix sums of width limit+1.
  function void note_word(bdc_pkg::amt_t limit_in, logic last);
    int unsigned       top;
    int unsigned       lim;
    longint unsigned   acc;
    longint unsigned   modulus;
    modulus = longint'(bdc_pkg::WayMod);
    top = (total > bdc_pkg::MaxTotalAmt) ? bdc_pkg::MaxTotal : int'(total);
    lim = (int'(limit_in) > top) ? top : int'(limit_in);
    acc = 0;
    for (int unsigned j = 0; j <= top; j++) begin
      acc = (acc + count_row[j]) % modulus;
      prefix_row[j] = bdc_pkg::cnt_t'(acc);
    end
    for (int unsigned j = 0; j <= top; j++) begin
      acc = prefix_row[j];
      if (j > lim) acc = (acc + modulus - prefix_row[j-lim-1]) % modulus;
      count_row[j] = bdc_pkg::cnt_t'(acc);
    end
    if (last) begin
      expected_q.push_back(count_row[top]);
      clear_row();
    end
  endfunction

  function void check_result(bdc_pkg::cnt_t got);
    bdc_pkg::cnt_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected way count %0d", got);
    end else begin
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("way count mismatch: expected %0d, got %0d", want, got);
      end
    end
  endfunction
endclass

module bounded_distribution_counter_unit_tb;

  localparam int          DrainCycles = 2200;
  localparam longint      CycleLimit  = 10000000;

  logic           clk;
  logic           rst_n;
  longint         cycles;
  int             send_idle_pct;
  int             take_stall_pct;
  int             run_left;
  way_count_board board;

  bdc_cfg_if cfg_bus ();
  bdc_in_if  item_bus ();
  bdc_out_if result_bus ();

  bounded_distribution_counter_unit u_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cfg_i    (cfg_bus),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stall the result side at random.
  always @(negedge clk) begin
    result_bus.ready = ($urandom_range(99) >= take_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && result_bus.valid && result_bus.ready) board.check_result(result_bus.way_count);
  end

  task automatic send_word(bdc_pkg::amt_t limit, logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_bus.valid = 1'b0;
      @(negedge clk);
    end
    item_bus.valid           = 1'b1;
    item_bus.recipient_limit = limit;
    item_bus.last_recipient  = last;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    board.note_word(limit, last);
  endtask

  // Hold until every result is back and the block has gone quiet.
  task automatic settle();
    @(negedge clk);
    item_bus.valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_total(bdc_pkg::amt_t value);
    settle();
    @(negedge clk);
    cfg_bus.valid        = 1'b1;
    cfg_bus.total_amount = value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    board.set_total(value);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  take_stall_pct = 0;  end
      1: begin send_idle_pct = 77; take_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  take_stall_pct = 77; end
      default: begin send_idle_pct = 24; take_stall_pct = 24; end
    endcase
  endtask

  function automatic bdc_pkg::amt_t pick_limit(int top);
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return bdc_pkg::amt_t'(top);
    if (r < 24) return bdc_pkg::amt_t'($urandom_range(2047));
    if (r < 32) return bdc_pkg::amt_t'((top + 3 > 2047) ? 2047 : top + $urandom_range(3, 1));
    return bdc_pkg::amt_t'($urandom_range(top));
  endfunction

  function automatic int pick_run_length();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(4, 1);
    if (r < 90) return $urandom_range(8, 5);
    return $urandom_range(24, 10);
  endfunction

  initial begin
    int            top;
    int            words;
    bdc_pkg::amt_t total;
    board                    = new();
    cycles                   = 0;
    send_idle_pct            = 0;
    take_stall_pct           = 0;
    run_left                 = 0;
    rst_n                    = 1'b0;
    cfg_bus.valid            = 1'b0;
    cfg_bus.total_amount     = '0;
    item_bus.valid           = 1'b0;
    item_bus.recipient_limit = '0;
    item_bus.last_recipient  = 1'b0;
    result_bus.ready         = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Total still at its reset value of zero.
    send_word(11'd0, 1'b1);
    send_word(11'd2047, 1'b1);

    write_total(11'd5);
    send_word(11'd5, 1'b1);
    send_word(11'd4, 1'b1);
    send_word(11'd2047, 1'b1);
    send_word(11'd2, 1'b0);
    send_word(11'd2, 1'b0);
    send_word(11'd2, 1'b1);
    send_word(11'd0, 1'b0);
    send_word(11'd5, 1'b1);

    write_total(bdc_pkg::MaxTotalAmt);
    send_word(11'd1024, 1'b0);
    send_word(11'd1024, 1'b0);
    send_word(11'd2047, 1'b1);

    write_total(11'd2047);
    send_word(11'd1024, 1'b0);
    send_word(11'd700, 1'b1);

    // Change the total inside an open run, lower then higher again.
    write_total(11'd7);
    send_word(11'd7, 1'b0);
    write_total(11'd2);
    send_word(11'd1, 1'b0);
    write_total(11'd7);
    send_word(11'd7, 1'b1);

    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0:  total = 11'd0;
        1:  total = 11'd1;
        2:  total = bdc_pkg::MaxTotalAmt;
        4:  total = bdc_pkg::amt_t'($urandom_range(300, 50));
        5:  total = 11'd2047;
        8:  total = bdc_pkg::amt_t'($urandom_range(600, 300));
        9:  total = bdc_pkg::amt_t'($urandom_range(16, 2));
        11: total = bdc_pkg::amt_t'($urandom_range(300, 100));
        13: total = bdc_pkg::amt_t'($urandom_range(10));
        default: total = bdc_pkg::amt_t'($urandom_range(40, 2));
      endcase
      write_total(total);
      set_idling(ph);
      top   = (total > bdc_pkg::MaxTotalAmt) ? bdc_pkg::MaxTotal : int'(total);
      words = (top > 400) ? 8 : 46;
      // An open run carries over into the next phase and its new total.
      for (int i = 0; i < words; i++) begin
        if (run_left == 0) run_left = pick_run_length();
        run_left--;
        send_word(pick_limit(top), run_left == 0);
      end
    end

    settle();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
